// ----- hdl/spq_pkg.sv -----
// Shared types for the strict priority queue with cancel.
// Operation codes, sequencer states and the command and result words.
// Used by spq_seq and strict_priority_queue_with_cancel.
`default_nettype none

package spq_pkg;

	localparam int QUEUE_DEPTH_DEF     = 16;
	localparam int PRIORITY_LEVELS_DEF = 3;
	localparam int PAYLOAD_BITS_DEF    = 32;

	typedef enum logic [1:0] {
		OP_ENQ    = 2'd0,
		OP_DEQ    = 2'd1,
		OP_CANCEL = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENQ,
		ST_DEQ,
		ST_DEQ_WAIT,
		ST_CAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t         op;
		logic [1:0]  level;
		logic [31:0] payload;
		logic [31:0] cancel_id;
	} cmd_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] entry_id;
		logic [31:0] payload;
		logic [1:0]  level;
		logic [4:0]  depth;
	} res_t;

endpackage

`default_nettype wire

// ----- hdl/spq_mem.sv -----
// Entry store for all priority levels: one write port, one registered read port.
// Depends on nothing else in the project.
`default_nettype none

module spq_mem #(
	parameter int DEPTH = 48,
	parameter int WIDTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/spq_seq.sv -----
// Sequencer of the priority queue: per-level ring pointers, id counter and the
// one-entry-per-cycle walk over the entry store. Depends on spq_pkg, spq_mem.
`default_nettype none

module spq_seq
	import spq_pkg::*;
#(
	parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF,
	parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF,
	parameter int PAYLOAD_BITS    = PAYLOAD_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire cmd_t cmd,
	output logic      idle,
	output logic      done,
	input  wire logic ack,
	output res_t      res
);

	localparam int LW = $clog2(PRIORITY_LEVELS);
	localparam int OW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SLOTS = PRIORITY_LEVELS * QUEUE_DEPTH;
	localparam int AW = $clog2(SLOTS);
	localparam int MW = 32 + PAYLOAD_BITS;
	localparam logic [3:0] LVL_LIMIT = 4'(PRIORITY_LEVELS);
	localparam logic [LW-1:0] LVL_LAST = LW'(PRIORITY_LEVELS - 1);
	localparam logic [OW-1:0] OFF_LAST = OW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);
	localparam logic [CW:0] SUM_WRAP = (CW + 1)'(QUEUE_DEPTH);

	state_t state_q, state_d;
	cmd_t   cmd_q;

	logic [OW-1:0] head_q [PRIORITY_LEVELS];
	logic [CW-1:0] count_q [PRIORITY_LEVELS];
	logic [31:0]   next_id_q;

	logic [LW-1:0] lv_q;
	logic [OW-1:0] rd_off_q, wr_off_q;
	logic [CW-1:0] rcnt_q, wcnt_q;
	logic          pend_q;

	logic                    res_ok_q;
	logic [31:0]             res_rid_q;
	logic [PAYLOAD_BITS-1:0] res_pay_q;
	logic [LW-1:0]           res_lvl_q;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [MW-1:0] wdata, rdata;

	logic          lvl_ok, full, enq_go;
	logic [LW-1:0] lidx;
	logic          any;
	logic [LW-1:0] sel;
	logic          issue, match, keep, lvl_end;

	function automatic logic [OW-1:0] inc_off(input logic [OW-1:0] x);
		return (x == OFF_LAST) ? '0 : x + 1'b1;
	endfunction

	function automatic logic [OW-1:0] add_off(input logic [OW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		s = (CW + 1)'(a) + (CW + 1)'(b);
		if (s >= SUM_WRAP) begin
			s = s - SUM_WRAP;
		end
		return OW'(s);
	endfunction

	function automatic logic [AW-1:0] slot(input logic [LW-1:0] lv, input logic [OW-1:0] off);
		return AW'(lv) * AW'(QUEUE_DEPTH) + AW'(off);
	endfunction

	spq_mem #(
		.DEPTH(SLOTS),
		.WIDTH(MW)
	) u_mem (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Level decode of the latched command; an out-of-range level points at level 0
	// but is never acted on.
	assign lvl_ok = {2'b00, cmd_q.level} < LVL_LIMIT;
	assign lidx   = lvl_ok ? LW'(cmd_q.level) : '0;
	assign full   = count_q[lidx] == CNT_FULL;
	assign enq_go = lvl_ok && !full;

	// Lowest-numbered non-empty level for a dequeue.
	always_comb begin
		any = 1'b0;
		sel = '0;
		for (int l = PRIORITY_LEVELS - 1; l >= 0; l--) begin
			if (count_q[l] != '0) begin
				any = 1'b1;
				sel = LW'(l);
			end
		end
	end

	// Compaction walk: each read's compare and write-back happen in the cycle after it is issued.
	assign issue   = rcnt_q != count_q[lv_q];
	assign match   = pend_q && (rdata[MW-1 -: 32] == cmd_q.cancel_id);
	assign keep    = pend_q && !match;
	assign lvl_end = !issue && !pend_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (cmd.op)
						OP_ENQ:    state_d = ST_ENQ;
						OP_DEQ:    state_d = ST_DEQ;
						OP_CANCEL: state_d = ST_CAN;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_ENQ:      state_d = ST_DONE;
			ST_DEQ:      state_d = any ? ST_DEQ_WAIT : ST_DONE;
			ST_DEQ_WAIT: state_d = ST_DONE;
			ST_CAN: begin
				if (lvl_end && lv_q == LVL_LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (ack) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = '0;
		raddr = '0;
		wdata = rdata;
		idle  = 1'b0;
		done  = 1'b0;
		case (state_q)
			ST_IDLE: idle = 1'b1;
			ST_ENQ: begin
				we    = enq_go;
				waddr = slot(lidx, add_off(head_q[lidx], count_q[lidx]));
				wdata = {next_id_q, PAYLOAD_BITS'(cmd_q.payload)};
			end
			ST_DEQ: begin
				re    = any;
				raddr = slot(sel, head_q[sel]);
			end
			ST_CAN: begin
				re    = issue;
				raddr = slot(lv_q, rd_off_q);
				we    = keep;
				waddr = slot(lv_q, wr_off_q);
			end
			ST_DONE: done = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			next_id_q <= '0;
			lv_q      <= '0;
			rd_off_q  <= '0;
			wr_off_q  <= '0;
			rcnt_q    <= '0;
			wcnt_q    <= '0;
			pend_q    <= 1'b0;
			for (int l = 0; l < PRIORITY_LEVELS; l++) begin
				head_q[l]  <= '0;
				count_q[l] <= '0;
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					lv_q     <= '0;
					rd_off_q <= head_q[0];
					wr_off_q <= head_q[0];
					rcnt_q   <= '0;
					wcnt_q   <= '0;
					pend_q   <= 1'b0;
				end
				ST_ENQ: begin
					next_id_q <= next_id_q + 32'd1;
					if (enq_go) begin
						count_q[lidx] <= count_q[lidx] + 1'b1;
					end
				end
				ST_DEQ: begin
					if (any) begin
						head_q[sel]  <= inc_off(head_q[sel]);
						count_q[sel] <= count_q[sel] - 1'b1;
					end
				end
				ST_CAN: begin
					pend_q <= issue;
					if (issue) begin
						rd_off_q <= inc_off(rd_off_q);
						rcnt_q   <= rcnt_q + 1'b1;
					end
					if (keep) begin
						wr_off_q <= inc_off(wr_off_q);
						wcnt_q   <= wcnt_q + 1'b1;
					end
					if (lvl_end) begin
						count_q[lv_q] <= wcnt_q;
						if (lv_q != LVL_LAST) begin
							lv_q     <= lv_q + 1'b1;
							rd_off_q <= head_q[lv_q + 1'b1];
							wr_off_q <= head_q[lv_q + 1'b1];
							rcnt_q   <= '0;
							wcnt_q   <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Result fields; they carry no reset since done qualifies them.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_q     <= cmd;
					res_ok_q  <= 1'b0;
					res_rid_q <= '0;
					res_pay_q <= '0;
					res_lvl_q <= '0;
				end
			end
			ST_ENQ: begin
				res_rid_q <= next_id_q;
				res_ok_q  <= enq_go;
			end
			ST_DEQ: begin
				if (any) begin
					res_ok_q  <= 1'b1;
					res_lvl_q <= sel;
				end
			end
			ST_DEQ_WAIT: begin
				res_rid_q <= rdata[MW-1 -: 32];
				res_pay_q <= rdata[PAYLOAD_BITS-1:0];
			end
			ST_CAN: begin
				if (match) begin
					res_ok_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		res.ok       = res_ok_q;
		res.entry_id = res_rid_q;
		res.payload  = 32'(res_pay_q);
		res.level    = 2'(res_lvl_q);
		res.depth    = lvl_ok ? 5'(count_q[lidx]) : 5'd0;
	end

endmodule

`default_nettype wire

// ----- hdl/strict_priority_queue_with_cancel.sv -----
// Strict priority queue with cancel by id: top level with the input and output handshakes.
// Enqueue writes one entry when its level is valid and not full; dequeue reads the head of the
// lowest-numbered non-empty level; an unknown op goes straight to the result; cancel walks every
// level in turn, reading its entries one after another and keeping those whose id differs.
// One word is in work at a time; a finished result waits in the output register while the next
// is accepted, and the sequencer stalls only when that register is full.
// Reset (arst_n low) empties all levels and restarts ids at zero; the store needs no clearing.
`default_nettype none

module strict_priority_queue_with_cancel
	import spq_pkg::*;
#(
	parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF,
	parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF,
	parameter int PAYLOAD_BITS    = PAYLOAD_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [1:0]  priority_req,
	input  wire logic [31:0] payload,
	input  wire logic [31:0] cancel_id,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             ok,
	output logic [31:0]      entry_id,
	output logic [31:0]      payload_out,
	output logic [1:0]       level_out,
	output logic [4:0]       level_depth
);

	logic seq_idle, seq_done, start, ack;
	cmd_t cmd;
	res_t res;
	res_t out_q;
	logic out_valid_q;

	// The sequencer takes a new word only when it has handed the previous result
	// to the output register, so in_ready follows its idle state.
	assign in_ready = seq_idle;
	assign start    = in_valid && in_ready;

	always_comb begin
		cmd.op        = op_t'(op);
		cmd.level     = priority_req;
		cmd.payload   = payload;
		cmd.cancel_id = cancel_id;
	end

	spq_seq #(
		.QUEUE_DEPTH    (QUEUE_DEPTH),
		.PRIORITY_LEVELS(PRIORITY_LEVELS),
		.PAYLOAD_BITS   (PAYLOAD_BITS)
	) u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.idle  (seq_idle),
		.done  (seq_done),
		.ack   (ack),
		.res   (res)
	);

	// The result moves into the output register when that register is empty or
	// is being emptied in the same cycle.
	assign ack = seq_done && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ack) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ack) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = out_q.ok;
	assign entry_id    = out_q.entry_id;
	assign payload_out = out_q.payload;
	assign level_out   = out_q.level;
	assign level_depth = out_q.depth;

endmodule

`default_nettype wire
